// ----- design/msa_pkg.sv -----
// shared types and constants of the magnetometer sample averager
package msa_pkg;

   localparam int AVG_WIDTH    = 24;
   localparam int SCALE_WIDTH  = 17;
   localparam int OVS_WIDTH    = 8;
   localparam int CSR_WIDTH    = 17;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_OVERSAMPLING    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGING_SCALE = 1'b1;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 17'h10000;

   typedef enum logic [1:0] {
      STATUS_SAMPLE    = 2'd0,
      STATUS_READY     = 2'd1,
      STATUS_READ_FAIL = 2'd2,
      STATUS_STALE     = 2'd3
   } status_type;

   typedef struct packed {
      logic replace;
      logic update;
   } lane_ctrl_type;

   typedef struct packed {
      status_type status;
      logic       reset_needed;
   } rsp_meta_type;

endpackage

// ----- design/msa_req_if.sv -----
// request channel: one raw sensor register read per word
interface msa_req_if;
   logic       valid;
   logic       ready;
   logic       read_ok;
   logic [7:0] bx_high;
   logic [7:0] by_high;
   logic [7:0] bz_high;
   logic [7:0] bxy_low;
   logic [7:0] flags_bz_low;
   logic [7:0] temp_frame;

   modport source (
      output valid, read_ok, bx_high, by_high, bz_high, bxy_low, flags_bz_low, temp_frame,
      input  ready
   );
   modport sink (
      input  valid, read_ok, bx_high, by_high, bz_high, bxy_low, flags_bz_low, temp_frame,
      output ready
   );
endinterface

// ----- design/msa_rsp_if.sv -----
// response channel: status and three axis averages per word
interface msa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic                                reset_needed;
   logic signed [msa_pkg::AVG_WIDTH-1:0] x_average;
   logic signed [msa_pkg::AVG_WIDTH-1:0] y_average;
   logic signed [msa_pkg::AVG_WIDTH-1:0] z_average;

   modport source (
      output valid, status, reset_needed, x_average, y_average, z_average,
      input  ready
   );
   modport sink (
      input  valid, status, reset_needed, x_average, y_average, z_average,
      output ready
   );
endinterface

// ----- design/msa_lane.sv -----
// one axis lane: unpack, replace or moving average update, average register
module msa_lane #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  msa_pkg::lane_ctrl_type               ctrl,
   input  logic [7:0]                           high,
   input  logic [3:0]                           nibble,
   input  logic [msa_pkg::SCALE_WIDTH-1:0]      scale,
   output logic signed [msa_pkg::AVG_WIDTH-1:0] avg_in
);

   localparam int TW = 12 + FRAC_BITS;
   localparam int DW = ((TW > msa_pkg::AVG_WIDTH) ? TW : msa_pkg::AVG_WIDTH) + 1;
   localparam int PW = DW + msa_pkg::SCALE_WIDTH + 1;

   localparam logic signed [PW-1:0] HALF     = PW'(32768);
   localparam logic signed [PW:0]   SAT_HI_P = (PW+1)'(8388607);
   localparam logic signed [PW:0]   SAT_LO_P = -(PW+1)'(8388608);
   localparam logic signed [DW-1:0] SAT_HI_D = DW'(8388607);
   localparam logic signed [DW-1:0] SAT_LO_D = -DW'(8388608);

   logic signed [msa_pkg::AVG_WIDTH-1:0] avg_ff;
   logic signed [11:0]   sample;
   logic signed [TW-1:0] target;
   logic signed [DW-1:0] target_ext;
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rounded;
   logic signed [PW:0]   total;
   logic signed [msa_pkg::AVG_WIDTH-1:0] ema_sat;
   logic signed [msa_pkg::AVG_WIDTH-1:0] target_sat;

   assign sample     = {high, nibble};
   assign target     = {sample, {FRAC_BITS{1'b0}}};
   assign target_ext = DW'(target);
   assign diff       = target_ext - DW'(avg_ff);
   assign prod       = PW'(diff) * PW'($signed({1'b0, scale}));
   assign rounded    = (prod + HALF) >>> 16;
   assign total      = (PW+1)'(avg_ff) + (PW+1)'(rounded);

   always_comb begin
      if (total > SAT_HI_P) begin
         ema_sat = SAT_HI_P[msa_pkg::AVG_WIDTH-1:0];
      end else if (total < SAT_LO_P) begin
         ema_sat = SAT_LO_P[msa_pkg::AVG_WIDTH-1:0];
      end else begin
         ema_sat = total[msa_pkg::AVG_WIDTH-1:0];
      end

      if (target_ext > SAT_HI_D) begin
         target_sat = SAT_HI_D[msa_pkg::AVG_WIDTH-1:0];
      end else if (target_ext < SAT_LO_D) begin
         target_sat = SAT_LO_D[msa_pkg::AVG_WIDTH-1:0];
      end else begin
         target_sat = target_ext[msa_pkg::AVG_WIDTH-1:0];
      end

      priority if (ctrl.replace) begin
         avg_in = target_sat;
      end else if (ctrl.update) begin
         avg_in = ema_sat;
      end else begin
         avg_in = avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

endmodule

// ----- design/msa_merge.sv -----
// merging stage: joins lane averages and status into the registered response
module msa_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  msa_pkg::rsp_meta_type                meta,
   input  logic signed [msa_pkg::AVG_WIDTH-1:0] x_in,
   input  logic signed [msa_pkg::AVG_WIDTH-1:0] y_in,
   input  logic signed [msa_pkg::AVG_WIDTH-1:0] z_in,
   msa_rsp_if.source                            rsp
);

   logic                                 valid_ff;
   logic                                 valid_in;
   msa_pkg::rsp_meta_type                meta_ff;
   logic signed [msa_pkg::AVG_WIDTH-1:0] x_ff;
   logic signed [msa_pkg::AVG_WIDTH-1:0] y_ff;
   logic signed [msa_pkg::AVG_WIDTH-1:0] z_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.status       = meta_ff.status;
   assign rsp.reset_needed = meta_ff.reset_needed;
   assign rsp.x_average    = x_ff;
   assign rsp.y_average    = y_ff;
   assign rsp.z_average    = z_ff;

endmodule

// ----- design/magnetic_sample_averager_core.sv -----
// top level of the magnetometer sample averager
// Takes one raw three-axis sensor read per word and returns one response word for each,
// holding the status, the reset request and the three axis averages in Q12.12. A word is
// taken in every cycle, even while the last response is read, unless an unread response
// stalls the input: the whole update, one 25 by 18 bit multiply per axis lane with
// its rounding and saturation, completes in the cycle the word is accepted, and the
// response appears in the next cycle from the output register. The user writes
// configuration registers only with no response outstanding; the block does not check.
module magnetic_sample_averager_core #(
   parameter int FRAC_BITS   = 12,
   parameter int ERROR_LIMIT = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   msa_req_if.sink                           req,
   msa_rsp_if.source                         rsp,
   input  logic                              csr_write_en,
   input  logic [msa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [msa_pkg::CSR_WIDTH-1:0]     csr_write_data
);

   localparam int EW = (ERROR_LIMIT > 1) ? $clog2(ERROR_LIMIT + 1) : 1;
   localparam logic [EW-1:0] ERR_LIM = EW'(ERROR_LIMIT);

   logic [msa_pkg::OVS_WIDTH-1:0]   ovs_ff;
   logic [msa_pkg::SCALE_WIDTH-1:0] scale_ff;
   logic [1:0]                      last_frame_ff;
   logic [1:0]                      last_frame_in;
   logic [EW-1:0]                   err_cnt_ff;
   logic [EW-1:0]                   err_cnt_in;
   logic [EW-1:0]                   err_inc;
   logic [msa_pkg::OVS_WIDTH-1:0]   smp_cnt_ff;
   logic [msa_pkg::OVS_WIDTH-1:0]   smp_cnt_in;
   logic [msa_pkg::OVS_WIDTH-1:0]   smp_inc;

   logic                            accept;
   logic [1:0]                      frame;
   msa_pkg::lane_ctrl_type          lane_ctrl;
   msa_pkg::rsp_meta_type           meta;
   logic signed [msa_pkg::AVG_WIDTH-1:0] x_next;
   logic signed [msa_pkg::AVG_WIDTH-1:0] y_next;
   logic signed [msa_pkg::AVG_WIDTH-1:0] z_next;

   assign req.ready = !rsp.valid || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign frame     = req.temp_frame[3:2];
   assign err_inc   = err_cnt_ff + EW'(1);
   assign smp_inc   = smp_cnt_ff + 8'd1;

   always_comb begin
      last_frame_in     = last_frame_ff;
      err_cnt_in        = err_cnt_ff;
      smp_cnt_in        = smp_cnt_ff;
      lane_ctrl         = '0;
      meta.status       = msa_pkg::STATUS_SAMPLE;
      meta.reset_needed = 1'b0;
      if (!req.read_ok || frame == last_frame_ff) begin
         meta.status = req.read_ok ? msa_pkg::STATUS_STALE : msa_pkg::STATUS_READ_FAIL;
         if (err_inc >= ERR_LIM) begin
            meta.reset_needed = 1'b1;
            err_cnt_in        = '0;
         end else begin
            err_cnt_in = err_inc;
         end
      end else begin
         err_cnt_in    = '0;
         last_frame_in = frame;
         if (ovs_ff == '0) begin
            lane_ctrl.replace = 1'b1;
            meta.status       = msa_pkg::STATUS_READY;
         end else begin
            lane_ctrl.update = 1'b1;
            if (smp_inc >= ovs_ff) begin
               meta.status = msa_pkg::STATUS_READY;
               smp_cnt_in  = '0;
            end else begin
               smp_cnt_in = smp_inc;
            end
         end
      end
      if (!accept) begin
         last_frame_in = last_frame_ff;
         err_cnt_in    = err_cnt_ff;
         smp_cnt_in    = smp_cnt_ff;
         lane_ctrl     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_frame_ff <= '0;
         err_cnt_ff    <= '0;
         smp_cnt_ff    <= '0;
         ovs_ff        <= '0;
         scale_ff      <= msa_pkg::SCALE_RESET;
      end else begin
         last_frame_ff <= last_frame_in;
         err_cnt_ff    <= err_cnt_in;
         smp_cnt_ff    <= smp_cnt_in;
         if (csr_write_en) begin
            unique case (csr_index)
               msa_pkg::CSR_OVERSAMPLING: begin
                  ovs_ff <= csr_write_data[msa_pkg::OVS_WIDTH-1:0];
               end
               msa_pkg::CSR_AVERAGING_SCALE: begin
                  scale_ff <= csr_write_data[msa_pkg::SCALE_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   msa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .high   (req.bx_high),
      .nibble (req.bxy_low[7:4]),
      .scale  (scale_ff),
      .avg_in (x_next)
   );

   msa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .high   (req.by_high),
      .nibble (req.bxy_low[3:0]),
      .scale  (scale_ff),
      .avg_in (y_next)
   );

   msa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .high   (req.bz_high),
      .nibble (req.flags_bz_low[3:0]),
      .scale  (scale_ff),
      .avg_in (z_next)
   );

   msa_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .meta   (meta),
      .x_in   (x_next),
      .y_in   (y_next),
      .z_in   (z_next),
      .rsp    (rsp)
   );

endmodule

// ----- tb/magnetic_sample_averager_core_tb.sv -----
`timescale 1ns / 100ps
// testbench of the magnetometer sample averager core: directed and random sensor reads against a predictor
module magnetic_sample_averager_core_tb;

   localparam int     FRAC_BITS   = 12;
   localparam int     ERROR_LIMIT = 3;
   localparam longint CYCLE_LIMIT = 600000;
   localparam longint AVG_HI      = 8388607;
   localparam longint AVG_LO      = -8388608;

   typedef enum int {READ_GOOD, READ_FAIL, READ_STALE} read_kind_type;

   typedef struct packed {
      logic       read_ok;
      logic [7:0] bx_high;
      logic [7:0] by_high;
      logic [7:0] bz_high;
      logic [7:0] bxy_low;
      logic [7:0] flags_bz_low;
      logic [7:0] temp_frame;
   } sensor_read_type;

   typedef struct {
      msa_pkg::status_type                  status;
      logic                                 reset_needed;
      logic signed [msa_pkg::AVG_WIDTH-1:0] x_average;
      logic signed [msa_pkg::AVG_WIDTH-1:0] y_average;
      logic signed [msa_pkg::AVG_WIDTH-1:0] z_average;
   } avg_frame_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [msa_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [msa_pkg::CSR_WIDTH-1:0]   csr_write_data;

   msa_req_if req_if ();
   msa_rsp_if rsp_if ();

   magnetic_sample_averager_core #(
      .FRAC_BITS   (FRAC_BITS),
      .ERROR_LIMIT (ERROR_LIMIT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state and settings
   logic [msa_pkg::OVS_WIDTH-1:0]        ovs_setting   = '0;
   logic [msa_pkg::SCALE_WIDTH-1:0]      scale_setting = msa_pkg::SCALE_RESET;
   logic [1:0]                           last_frame    = '0;
   int unsigned                          error_run     = 0;
   logic [7:0]                           sample_count  = '0;
   logic signed [msa_pkg::AVG_WIDTH-1:0] x_avg         = '0;
   logic signed [msa_pkg::AVG_WIDTH-1:0] y_avg         = '0;
   logic signed [msa_pkg::AVG_WIDTH-1:0] z_avg         = '0;
   avg_frame_type                        frames_due[$];

   int     fail_count     = 0;
   int     reads_sent     = 0;
   int     frames_checked = 0;
   int     ready_frames   = 0;
   int     reset_requests = 0;
   int     settings_used  = 0;
   longint cycle_count    = 0;
   bit     req_gaps_on    = 1'b1;
   bit     rsp_gaps_on    = 1'b1;
   int     rsp_hold       = 0;
   int     rsp_hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint unpack_axis(logic [7:0] hi, logic [3:0] nib);
      longint raw;
      raw = longint'({hi, nib});
      if (raw >= 2048) raw -= 4096;
      return raw;
   endfunction

   function automatic logic signed [msa_pkg::AVG_WIDTH-1:0] clamp_avg(longint v);
      if (v > AVG_HI) v = AVG_HI;
      else if (v < AVG_LO) v = AVG_LO;
      return v[msa_pkg::AVG_WIDTH-1:0];
   endfunction

   // moving average step, rounding half up then saturating
   function automatic logic signed [msa_pkg::AVG_WIDTH-1:0] ema_step(
      logic signed [msa_pkg::AVG_WIDTH-1:0] avg, longint smp);
      longint prod;
      prod = ((smp <<< FRAC_BITS) - longint'(avg)) * longint'(scale_setting);
      return clamp_avg(longint'(avg) + ((prod + 32768) >>> 16));
   endfunction

   function automatic void apply_sensor_read(sensor_read_type rd);
      avg_frame_type f;
      logic [1:0]    frame;
      longint        x, y, z;
      frame = rd.temp_frame[3:2];
      f.reset_needed = 1'b0;
      if (!rd.read_ok || frame == last_frame) begin
         f.status = rd.read_ok ? msa_pkg::STATUS_STALE : msa_pkg::STATUS_READ_FAIL;
         error_run++;
         if (error_run >= ERROR_LIMIT) begin
            f.reset_needed = 1'b1;
            error_run = 0;
         end
      end else begin
         x = unpack_axis(rd.bx_high, rd.bxy_low[7:4]);
         y = unpack_axis(rd.by_high, rd.bxy_low[3:0]);
         z = unpack_axis(rd.bz_high, rd.flags_bz_low[3:0]);
         error_run = 0;
         last_frame = frame;
         if (ovs_setting == 0) begin
            x_avg = clamp_avg(x <<< FRAC_BITS);
            y_avg = clamp_avg(y <<< FRAC_BITS);
            z_avg = clamp_avg(z <<< FRAC_BITS);
            f.status = msa_pkg::STATUS_READY;
         end else begin
            x_avg = ema_step(x_avg, x);
            y_avg = ema_step(y_avg, y);
            z_avg = ema_step(z_avg, z);
            sample_count = sample_count + 8'd1;
            f.status = msa_pkg::STATUS_SAMPLE;
            if (sample_count >= ovs_setting) begin
               f.status = msa_pkg::STATUS_READY;
               sample_count = '0;
            end
         end
      end
      f.x_average = x_avg;
      f.y_average = y_avg;
      f.z_average = z_avg;
      frames_due.push_back(f);
   endfunction

   function automatic sensor_read_type build_read(logic ok, logic [1:0] frame,
                                                  logic [11:0] x, logic [11:0] y,
                                                  logic [11:0] z, logic [15:0] junk);
      sensor_read_type rd;
      rd.read_ok      = ok;
      rd.bx_high      = x[11:4];
      rd.by_high      = y[11:4];
      rd.bz_high      = z[11:4];
      rd.bxy_low      = {x[3:0], y[3:0]};
      rd.flags_bz_low = {junk[11:8], z[3:0]};
      rd.temp_frame   = {junk[7:4], frame, junk[1:0]};
      return rd;
   endfunction

   function automatic logic [11:0] random_axis();
      case ($urandom_range(0, 19))
         0: return 12'h7ff;
         1: return 12'h800;
         2: return 12'hfff;
         3: return 12'h000;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic read_kind_type random_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 84) return READ_GOOD;
      if (r < 92) return READ_FAIL;
      return READ_STALE;
   endfunction

   function automatic sensor_read_type random_read(read_kind_type kind);
      logic [1:0] frame;
      case (kind)
         READ_GOOD:  frame = last_frame + 2'($urandom_range(1, 3));
         READ_FAIL:  frame = 2'($urandom_range(0, 3));
         default:    frame = last_frame;
      endcase
      return build_read(kind != READ_FAIL, frame, random_axis(), random_axis(), random_axis(),
                        16'($urandom_range(0, 65535)));
   endfunction

   task automatic send_sensor_read(sensor_read_type rd);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.read_ok      = rd.read_ok;
      req_if.bx_high      = rd.bx_high;
      req_if.by_high      = rd.by_high;
      req_if.bz_high      = rd.bz_high;
      req_if.bxy_low      = rd.bxy_low;
      req_if.flags_bz_low = rd.flags_bz_low;
      req_if.temp_frame   = rd.temp_frame;
      req_if.valid        = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      apply_sensor_read(rd);
      reads_sent++;
   endtask

   task automatic drain_frames();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(logic [msa_pkg::CSR_IDX_W-1:0] idx,
                            logic [msa_pkg::CSR_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = data;
      @(posedge clock);
      if (idx == msa_pkg::CSR_OVERSAMPLING) ovs_setting = data[msa_pkg::OVS_WIDTH-1:0];
      else scale_setting = data[msa_pkg::SCALE_WIDTH-1:0];
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic configure(logic [msa_pkg::CSR_WIDTH-1:0] ovs,
                            logic [msa_pkg::CSR_WIDTH-1:0] scale);
      drain_frames();
      write_csr(msa_pkg::CSR_OVERSAMPLING, ovs);
      write_csr(msa_pkg::CSR_AVERAGING_SCALE, scale);
      settings_used++;
   endtask

   task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_frame();
      avg_frame_type f;
      if (frames_due.size() == 0) begin
         $display("%0t: response word with nothing outstanding, status %0d", $time,
                  rsp_if.status);
         fail_count++;
      end else begin
         f = frames_due.pop_front();
         compare_field("status", f.status, rsp_if.status);
         compare_field("reset_needed", f.reset_needed, rsp_if.reset_needed);
         compare_field("x_average", f.x_average, rsp_if.x_average);
         compare_field("y_average", f.y_average, rsp_if.y_average);
         compare_field("z_average", f.z_average, rsp_if.z_average);
         frames_checked++;
         if (f.status == msa_pkg::STATUS_READY) ready_frames++;
         if (f.reset_needed) reset_requests++;
      end
   endtask

   // response side: random holds, plus long holds on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            rsp_hold = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_hold > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_if.ready = 1'b1;
         end
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            check_frame();
            rsp_hold = rsp_gaps_on ? pick_gap() : 0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("magnetic_sample_averager_core_tb: FAIL");
      $finish;
   end

   task automatic test_pass_through_and_errors();
      send_sensor_read(build_read(1'b1, 2'd0, 12'h000, 12'h000, 12'h000, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd1, 12'h7ff, 12'h7ff, 12'h7ff, 16'hffff));
      send_sensor_read(build_read(1'b1, 2'd2, 12'h800, 12'h800, 12'h800, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd3, 12'hfff, 12'h001, 12'h800, 16'h5a5a));
      // three errors in a row, then the count starts again
      send_sensor_read(build_read(1'b0, 2'd0, 12'h123, 12'h456, 12'h789, 16'ha5a5));
      send_sensor_read(build_read(1'b1, 2'd3, 12'h321, 12'h654, 12'h987, 16'h0f0f));
      send_sensor_read(build_read(1'b0, 2'd1, 12'h7ff, 12'h800, 12'h000, 16'hf0f0));
      send_sensor_read(build_read(1'b1, 2'd3, 12'h000, 12'hfff, 12'h7ff, 16'h3c3c));
      send_sensor_read(build_read(1'b0, 2'd2, 12'h800, 12'h7ff, 12'hfff, 16'hc3c3));
      send_sensor_read(build_read(1'b1, 2'd0, 12'h123, 12'h456, 12'h789, 16'hffff));
      send_sensor_read(build_read(1'b0, 2'd0, 12'h000, 12'h000, 12'h000, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd1, 12'hedc, 12'hba9, 12'h876, 16'h1234));
   endtask

   task automatic test_averaging_directed();
      // upper data bits beyond the oversampling field are dropped
      configure(17'h1_0002, 17'h1_0000);
      send_sensor_read(build_read(1'b1, 2'd2, 12'h7ff, 12'h7ff, 12'h7ff, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd3, 12'h800, 12'h800, 12'h800, 16'hffff));
      // weight above one saturates
      configure(17'd3, 17'h1_ffff);
      send_sensor_read(build_read(1'b1, 2'd0, 12'h7ff, 12'h800, 12'h7ff, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd1, 12'h800, 12'h7ff, 12'h800, 16'h0000));
      send_sensor_read(build_read(1'b1, 2'd2, 12'h7ff, 12'h800, 12'h7ff, 16'h0000));
      send_sensor_read(build_read(1'b0, 2'd3, 12'h000, 12'h000, 12'h000, 16'h0000));
      // zero weight freezes the averages
      configure(17'd1, 17'd0);
      send_sensor_read(build_read(1'b1, 2'd3, 12'h123, 12'h456, 12'h789, 16'h0000));
      configure(17'd1, 17'd1);
      send_sensor_read(build_read(1'b1, 2'd0, 12'h800, 12'h001, 12'hfff, 16'h0000));
   endtask

   task automatic test_random_phases();
      int unsigned ovs_tab   [12] = '{0, 255, 1, 2, 4, 0, 8, 16, 3, 32, 0, 0};
      int unsigned scale_tab [12] = '{65536, 256, 0, 32768, 16384, 65536, 8192, 131071,
                                      21845, 2048, 0, 0};
      int          reads;
      ovs_tab[10]   = $urandom_range(1, 12);
      scale_tab[10] = $urandom_range(0, 131071);
      ovs_tab[11]   = $urandom_range(0, 6);
      scale_tab[11] = $urandom_range(0, 65536);
      for (int p = 0; p < 12; p++) begin
         configure(msa_pkg::CSR_WIDTH'(ovs_tab[p]), msa_pkg::CSR_WIDTH'(scale_tab[p]));
         req_gaps_on = (p % 4 == 0) || (p % 4 == 2);
         rsp_gaps_on = (p % 4 == 0) || (p % 4 == 1);
         reads = (ovs_tab[p] == 255) ? 400 : 115;
         repeat (reads) send_sensor_read(random_read(random_kind()));
      end
   endtask

   task automatic test_backpressure();
      configure(17'd4, 17'd16384);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      @(posedge clock);
      rsp_hold_request = 150;
      repeat (30) send_sensor_read(random_read(random_kind()));
      // sender waits for every outstanding word before carrying on
      drain_frames();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (10) send_sensor_read(random_read(random_kind()));
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_if.valid        = 1'b0;
      req_if.read_ok      = 1'b0;
      req_if.bx_high      = '0;
      req_if.by_high      = '0;
      req_if.bz_high      = '0;
      req_if.bxy_low      = '0;
      req_if.flags_bz_low = '0;
      req_if.temp_frame   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pass_through_and_errors();
      test_averaging_directed();
      test_random_phases();
      test_backpressure();

      drain_frames();
      repeat (4) @(posedge clock);
      $display("sent %0d sensor reads over %0d register settings, %0d responses checked",
               reads_sent, settings_used + 1, frames_checked);
      $display("%0d ready frames, %0d reset requests, %0d mismatches",
               ready_frames, reset_requests, fail_count);
      if (fail_count == 0) begin
         $display("magnetic_sample_averager_core_tb: PASS");
      end else begin
         $display("magnetic_sample_averager_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/msa_pkg.sv
design/msa_req_if.sv
design/msa_rsp_if.sv
design/msa_lane.sv
design/msa_merge.sv
design/magnetic_sample_averager_core.sv
tb/magnetic_sample_averager_core_tb.sv
